### rtl/mvd_pkg.sv
package mvd_pkg;

    localparam int POINT_DEPTH  = 1024;
    localparam int VERTEX_DEPTH = 1024;

    localparam int PT_AW  = $clog2(POINT_DEPTH);
    localparam int VX_AW  = $clog2(VERTEX_DEPTH);
    localparam int PCNT_W = $clog2(POINT_DEPTH + 1);
    localparam int VCNT_W = $clog2(VERTEX_DEPTH + 1);

    localparam int IDX_W  = 10;
    localparam int CRN_W  = 10;
    localparam int CRD_W  = 16;
    localparam int POS_W  = 3 * CRD_W;
    localparam int UV_W   = 2 * CRD_W;
    localparam int PT_W   = POS_W + UV_W;
    localparam int VX_W   = 2 * POS_W + UV_W;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_CRN   = 2'd1,
        STAT_PT_FULL   = 2'd2,
        STAT_VX_FULL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POINT,
        ST_CHECK,
        ST_PRD,
        ST_NSTART,
        ST_NWAIT,
        ST_LOAD,
        ST_SRCH,
        ST_EMIT
    } mvd_state_t;

    typedef enum logic [2:0] {
        NRM_IDLE,
        NRM_MUL,
        NRM_SQR,
        NRM_ROOT,
        NRM_DIV,
        NRM_DONE
    } nrm_state_t;

endpackage

### rtl/mvd_ram.sv
module mvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/mvd_nrm.sv
module mvd_nrm
    import mvd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] p0,
    input  logic [POS_W-1:0] p1,
    input  logic [POS_W-1:0] p2,
    output logic             done,
    output logic [POS_W-1:0] n
);

    localparam int DW   = CRD_W + 1;
    localparam int PW   = 2 * DW;
    localparam int CW   = PW + 1;
    localparam int SQW  = 2 * CW;
    localparam int SW   = SQW + 2;
    localparam int RTW  = SW / 2;
    localparam int RMW  = RTW + 3;
    localparam int QFR  = 14;
    localparam int NUMW = CW + QFR;
    localparam int DRW  = RTW + 1;

    nrm_state_t st_reg, st_next;

    logic signed [DW-1:0]  d0_reg [3];
    logic signed [DW-1:0]  d0_next [3];
    logic signed [DW-1:0]  d1_reg [3];
    logic signed [DW-1:0]  d1_next [3];
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [CW-1:0]  cr_reg [3];
    logic signed [CW-1:0]  cr_next [3];
    logic [5:0]            cnt_reg, cnt_next;
    logic [1:0]            ax_reg, ax_next;
    logic [SQW-1:0]        sqa_reg, sqa_next;
    logic [CW-1:0]         sqb_reg, sqb_next;
    logic [SW-1:0]         sum_reg, sum_next;
    logic [RMW-1:0]        rem_reg, rem_next;
    logic [RTW-1:0]        root_reg, root_next;
    logic [NUMW-1:0]       dvd_reg, dvd_next;
    logic [DRW-1:0]        drem_reg, drem_next;
    logic [CRD_W-1:0]      q_reg, q_next;
    logic [CRD_W-1:0]      n_reg [3];
    logic [CRD_W-1:0]      n_next [3];

    logic signed [DW-1:0]  ma, mb;
    logic [2:0]            mstep;
    logic [1:0]            cidx;
    logic signed [CW-1:0]  cr_sel;
    logic [RMW-1:0]        rrem2, rtrial;
    logic [DRW:0]          drem2;
    logic [CRD_W-1:0]      qfin;

    function automatic logic signed [DW-1:0] sx(input logic [CRD_W-1:0] v);
        return signed'({v[CRD_W-1], v});
    endfunction

    function automatic logic [CW-1:0] absv(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            NRM_IDLE: if (start) st_next = NRM_MUL;
            NRM_MUL:  if (cnt_reg == 6'd6) st_next = NRM_SQR;
            NRM_SQR:  if (cnt_reg == 6'(CW - 1) && ax_reg == 2'd2) st_next = NRM_ROOT;
            NRM_ROOT: if (cnt_reg == 6'(RTW - 1)) st_next = NRM_DIV;
            NRM_DIV:  if (cnt_reg == 6'(NUMW - 1) && ax_reg == 2'd2) st_next = NRM_DONE;
            NRM_DONE: st_next = NRM_IDLE;
            default:  st_next = NRM_IDLE;
        endcase
    end

    always_comb
    begin
        d0_next   = d0_reg;
        d1_next   = d1_reg;
        prod_next = prod_reg;
        cr_next   = cr_reg;
        cnt_next  = cnt_reg;
        ax_next   = ax_reg;
        sqa_next  = sqa_reg;
        sqb_next  = sqb_reg;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dvd_next  = dvd_reg;
        drem_next = drem_reg;
        q_next    = q_reg;
        n_next    = n_reg;
        ma        = '0;
        mb        = '0;
        mstep     = 3'(cnt_reg - 6'd1);
        cidx      = 2'(mstep >> 1);
        rrem2     = {rem_reg[RMW-3:0], sum_reg[SW-1:SW-2]};
        rtrial    = {1'b0, root_reg, 2'b01};
        drem2     = {drem_reg, dvd_reg[NUMW-1]};
        qfin      = {q_reg[CRD_W-2:0], 1'b0};

        case (ax_reg)
            2'd0:    cr_sel = cr_reg[1];
            2'd1:    cr_sel = cr_reg[2];
            default: cr_sel = cr_reg[0];
        endcase

        case (st_reg)
            NRM_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        d0_next[i] = sx(p1[POS_W-1-CRD_W*i -: CRD_W])
                                   - sx(p0[POS_W-1-CRD_W*i -: CRD_W]);
                        d1_next[i] = sx(p2[POS_W-1-CRD_W*i -: CRD_W])
                                   - sx(p1[POS_W-1-CRD_W*i -: CRD_W]);
                        cr_next[i] = '0;
                    end
                    cnt_next = '0;
                end
            end
            NRM_MUL:
            begin
                case (cnt_reg[2:0])
                    3'd0:    begin ma = d0_reg[1]; mb = d1_reg[2]; end
                    3'd1:    begin ma = d0_reg[2]; mb = d1_reg[1]; end
                    3'd2:    begin ma = d0_reg[2]; mb = d1_reg[0]; end
                    3'd3:    begin ma = d0_reg[0]; mb = d1_reg[2]; end
                    3'd4:    begin ma = d0_reg[0]; mb = d1_reg[1]; end
                    3'd5:    begin ma = d0_reg[1]; mb = d1_reg[0]; end
                    default: begin ma = '0; mb = '0; end
                endcase
                prod_next = ma * mb;
                if (cnt_reg != 6'd0)
                begin
                    if (mstep[0])
                        cr_next[cidx] = cr_reg[cidx] - CW'(prod_reg);
                    else
                        cr_next[cidx] = cr_reg[cidx] + CW'(prod_reg);
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd6)
                begin
                    ax_next  = 2'd0;
                    cnt_next = '0;
                    sum_next = '0;
                    sqa_next = SQW'(absv(cr_reg[0]));
                    sqb_next = absv(cr_reg[0]);
                end
            end
            NRM_SQR:
            begin
                if (sqb_reg[0])
                    sum_next = sum_reg + SW'(sqa_reg);
                sqa_next = sqa_reg << 1;
                sqb_next = sqb_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CW - 1))
                begin
                    cnt_next = '0;
                    if (ax_reg == 2'd2)
                    begin
                        rem_next  = '0;
                        root_next = '0;
                    end
                    else
                    begin
                        ax_next  = ax_reg + 2'd1;
                        sqa_next = SQW'(absv(cr_sel));
                        sqb_next = absv(cr_sel);
                    end
                end
            end
            NRM_ROOT:
            begin
                if (rrem2 >= rtrial)
                begin
                    rem_next  = rrem2 - rtrial;
                    root_next = {root_reg[RTW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rrem2;
                    root_next = {root_reg[RTW-2:0], 1'b0};
                end
                sum_next = sum_reg << 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(RTW - 1))
                begin
                    cnt_next  = '0;
                    ax_next   = 2'd0;
                    drem_next = '0;
                    dvd_next  = {absv(cr_reg[0]), QFR'(0)};
                end
            end
            NRM_DIV:
            begin
                if (drem2 >= (DRW + 1)'(root_reg))
                begin
                    drem_next = DRW'(drem2 - (DRW + 1)'(root_reg));
                    qfin[0]   = 1'b1;
                end
                else
                begin
                    drem_next = DRW'(drem2);
                end
                q_next   = qfin;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NUMW - 1))
                begin
                    cnt_next = '0;
                    if (root_reg == '0)
                        n_next[ax_reg] = '0;
                    else if (cr_reg[ax_reg][CW-1])
                        n_next[ax_reg] = CRD_W'(-qfin);
                    else
                        n_next[ax_reg] = qfin;
                    if (ax_reg != 2'd2)
                    begin
                        ax_next   = ax_reg + 2'd1;
                        drem_next = '0;
                        dvd_next  = {absv(cr_sel), QFR'(0)};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= NRM_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d0_reg   <= d0_next;
        d1_reg   <= d1_next;
        prod_reg <= prod_next;
        cr_reg   <= cr_next;
        cnt_reg  <= cnt_next;
        ax_reg   <= ax_next;
        sqa_reg  <= sqa_next;
        sqb_reg  <= sqb_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvd_reg  <= dvd_next;
        drem_reg <= drem_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
    end

    assign done = (st_reg == NRM_DONE);
    assign n    = {n_reg[0], n_reg[1], n_reg[2]};

endmodule

### rtl/triangle_normal_vertex_dedup_core.sv
// Channel  Handshake            Payload
// input    in_valid / in_stall  req_type pos_x pos_y pos_z tex_u tex_v corner_a..c
// output   out_valid/ out_stall index is_new last status out_x..z normal_x..z out_u out_v
//
// Add point: the point is written to the point table, then the output transfer.
// Add triangle: the three corner points are read, then the normal unit runs (cross products,
// serial squares, 36-step root, three 49-step divisions), then per corner the stored
// vertices are scanned, one vertex memory read per cycle, until a match or the end.
// Reset clears counts and control only; tables need no clearing pass.
// in_stall is high from the accepting edge until the item is finished.
module triangle_normal_vertex_dedup_core
    import mvd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    req_type,
    input  logic signed [CRD_W-1:0] pos_x,
    input  logic signed [CRD_W-1:0] pos_y,
    input  logic signed [CRD_W-1:0] pos_z,
    input  logic signed [CRD_W-1:0] tex_u,
    input  logic signed [CRD_W-1:0] tex_v,
    input  logic [CRN_W-1:0]        corner_a,
    input  logic [CRN_W-1:0]        corner_b,
    input  logic [CRN_W-1:0]        corner_c,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [IDX_W-1:0]        index,
    output logic                    is_new,
    output logic                    last,
    output logic [1:0]              status,
    output logic signed [CRD_W-1:0] out_x,
    output logic signed [CRD_W-1:0] out_y,
    output logic signed [CRD_W-1:0] out_z,
    output logic signed [CRD_W-1:0] normal_x,
    output logic signed [CRD_W-1:0] normal_y,
    output logic signed [CRD_W-1:0] normal_z,
    output logic signed [CRD_W-1:0] out_u,
    output logic signed [CRD_W-1:0] out_v
);

    mvd_state_t state_reg, state_next;

    logic [POS_W-1:0]  rq_pos_reg, rq_pos_next;
    logic [UV_W-1:0]   rq_uv_reg, rq_uv_next;
    logic [CRN_W-1:0]  crn_reg [3];
    logic [CRN_W-1:0]  crn_next [3];
    logic [PCNT_W-1:0] pcount_reg, pcount_next;
    logic [VCNT_W-1:0] vcount_reg, vcount_next;
    logic [1:0]        rk_reg, rk_next;
    logic [1:0]        k_reg, k_next;
    logic [PT_W-1:0]   pt_reg [3];
    logic [PT_W-1:0]   pt_next [3];
    logic [VX_W-1:0]   cur_reg, cur_next;
    logic [VCNT_W-1:0] rd_j_reg, rd_j_next;
    logic              cmp_v_reg, cmp_v_next;
    logic [VX_AW-1:0]  cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]  res_idx_reg, res_idx_next;
    logic              res_new_reg, res_new_next;
    logic              res_last_reg, res_last_next;
    status_t           res_stat_reg, res_stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_new_reg, out_new_next;
    logic              out_last_reg, out_last_next;
    status_t           out_stat_reg, out_stat_next;
    logic [VX_W-1:0]   out_vtx_reg, out_vtx_next;

    logic              pt_we;
    logic [PT_AW-1:0]  pt_waddr, pt_raddr;
    logic [PT_W-1:0]   pt_wdata, pt_rdata;
    logic              vx_we;
    logic [VX_AW-1:0]  vx_waddr;
    logic [VX_W-1:0]   vx_rdata;
    logic              nrm_start, nrm_done;
    logic [POS_W-1:0]  nrm_n;
    logic              bad, hit, slot_free, scan_end;
    logic [PT_W-1:0]   pt_sel;

    mvd_ram #(.WIDTH(PT_W), .DEPTH(POINT_DEPTH)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .raddr (pt_raddr),
        .rdata (pt_rdata)
    );

    mvd_ram #(.WIDTH(VX_W), .DEPTH(VERTEX_DEPTH)) u_vx_ram (
        .clk   (clk),
        .we    (vx_we),
        .waddr (vx_waddr),
        .wdata (cur_reg),
        .raddr (VX_AW'(rd_j_reg)),
        .rdata (vx_rdata)
    );

    mvd_nrm u_nrm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nrm_start),
        .p0    (pt_reg[0][PT_W-1 -: POS_W]),
        .p1    (pt_reg[1][PT_W-1 -: POS_W]),
        .p2    (pt_reg[2][PT_W-1 -: POS_W]),
        .done  (nrm_done),
        .n     (nrm_n)
    );

    assign bad = (32'(crn_reg[0]) >= 32'(pcount_reg)) ||
                 (32'(crn_reg[1]) >= 32'(pcount_reg)) ||
                 (32'(crn_reg[2]) >= 32'(pcount_reg));
    assign hit       = cmp_v_reg && (vx_rdata == cur_reg);
    assign scan_end  = (rd_j_reg == vcount_reg);
    assign slot_free = !out_valid_reg || !out_stall;
    assign nrm_start = (state_reg == ST_NSTART);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = req_type ? ST_CHECK : ST_POINT;
            ST_POINT:  state_next = ST_EMIT;
            ST_CHECK:  state_next = bad ? ST_EMIT : ST_PRD;
            ST_PRD:    if (rk_reg == 2'd3) state_next = ST_NSTART;
            ST_NSTART: state_next = ST_NWAIT;
            ST_NWAIT:  if (nrm_done) state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_SRCH;
            ST_SRCH:   if (hit || scan_end) state_next = ST_EMIT;
            ST_EMIT:   if (slot_free) state_next = res_last_reg ? ST_IDLE : ST_LOAD;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rq_pos_next    = rq_pos_reg;
        rq_uv_next     = rq_uv_reg;
        crn_next       = crn_reg;
        pcount_next    = pcount_reg;
        vcount_next    = vcount_reg;
        rk_next        = rk_reg;
        k_next         = k_reg;
        pt_next        = pt_reg;
        cur_next       = cur_reg;
        rd_j_next      = rd_j_reg;
        cmp_v_next     = cmp_v_reg;
        cmp_idx_next   = cmp_idx_reg;
        res_idx_next   = res_idx_reg;
        res_new_next   = res_new_reg;
        res_last_next  = res_last_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_idx_next   = out_idx_reg;
        out_new_next   = out_new_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;
        out_vtx_next   = out_vtx_reg;
        pt_we          = 1'b0;
        pt_waddr       = PT_AW'(pcount_reg);
        pt_wdata       = {rq_pos_reg, rq_uv_reg};
        vx_we          = 1'b0;
        vx_waddr       = VX_AW'(vcount_reg);

        case (rk_reg)
            2'd0:    pt_raddr = PT_AW'(crn_reg[0]);
            2'd1:    pt_raddr = PT_AW'(crn_reg[1]);
            default: pt_raddr = PT_AW'(crn_reg[2]);
        endcase

        case (k_reg)
            2'd0:    pt_sel = pt_reg[0];
            2'd1:    pt_sel = pt_reg[1];
            default: pt_sel = pt_reg[2];
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    rq_pos_next = {pos_x, pos_y, pos_z};
                    rq_uv_next  = {tex_u, tex_v};
                    crn_next[0] = corner_a;
                    crn_next[1] = corner_b;
                    crn_next[2] = corner_c;
                end
            end
            ST_POINT:
            begin
                cur_next      = {rq_pos_reg, POS_W'(0), rq_uv_reg};
                res_new_next  = 1'b0;
                res_last_next = 1'b1;
                if (pcount_reg == PCNT_W'(POINT_DEPTH))
                begin
                    res_stat_next = STAT_PT_FULL;
                    res_idx_next  = '0;
                end
                else
                begin
                    pt_we         = 1'b1;
                    res_stat_next = STAT_OK;
                    res_idx_next  = IDX_W'(pcount_reg);
                    pcount_next   = pcount_reg + PCNT_W'(1);
                end
            end
            ST_CHECK:
            begin
                rk_next = 2'd0;
                if (bad)
                begin
                    cur_next      = '0;
                    res_stat_next = STAT_BAD_CRN;
                    res_idx_next  = '0;
                    res_new_next  = 1'b0;
                    res_last_next = 1'b1;
                end
            end
            ST_PRD:
            begin
                case (rk_reg)
                    2'd1:    pt_next[0] = pt_rdata;
                    2'd2:    pt_next[1] = pt_rdata;
                    2'd3:    pt_next[2] = pt_rdata;
                    default: ;
                endcase
                rk_next = rk_reg + 2'd1;
                k_next  = 2'd0;
            end
            ST_LOAD:
            begin
                cur_next   = {pt_sel[PT_W-1 -: POS_W], nrm_n, pt_sel[UV_W-1:0]};
                rd_j_next  = '0;
                cmp_v_next = 1'b0;
            end
            ST_SRCH:
            begin
                res_last_next = (k_reg == 2'd2);
                if (hit)
                begin
                    res_idx_next  = IDX_W'(cmp_idx_reg);
                    res_new_next  = 1'b0;
                    res_stat_next = STAT_OK;
                end
                else if (scan_end)
                begin
                    if (vcount_reg == VCNT_W'(VERTEX_DEPTH))
                    begin
                        res_idx_next  = '0;
                        res_new_next  = 1'b0;
                        res_stat_next = STAT_VX_FULL;
                    end
                    else
                    begin
                        vx_we         = 1'b1;
                        res_idx_next  = IDX_W'(vcount_reg);
                        res_new_next  = 1'b1;
                        res_stat_next = STAT_OK;
                        vcount_next   = vcount_reg + VCNT_W'(1);
                    end
                end
                else
                begin
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = VX_AW'(rd_j_reg);
                    rd_j_next    = rd_j_reg + VCNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_new_next   = res_new_reg;
                    out_last_next  = res_last_reg;
                    out_stat_next  = res_stat_reg;
                    out_vtx_next   = cur_reg;
                    k_next         = k_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pcount_reg    <= '0;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            cmp_v_reg     <= 1'b0;
            rk_reg        <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pcount_reg    <= pcount_next;
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
            cmp_v_reg     <= cmp_v_next;
            rk_reg        <= rk_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_pos_reg   <= rq_pos_next;
        rq_uv_reg    <= rq_uv_next;
        crn_reg      <= crn_next;
        pt_reg       <= pt_next;
        cur_reg      <= cur_next;
        rd_j_reg     <= rd_j_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_last_reg <= res_last_next;
        res_stat_reg <= res_stat_next;
        out_idx_reg  <= out_idx_next;
        out_new_reg  <= out_new_next;
        out_last_reg <= out_last_next;
        out_stat_reg <= out_stat_next;
        out_vtx_reg  <= out_vtx_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign index     = out_idx_reg;
    assign is_new    = out_new_reg;
    assign last      = out_last_reg;
    assign status    = out_stat_reg;
    assign out_x     = out_vtx_reg[VX_W-1 -: CRD_W];
    assign out_y     = out_vtx_reg[VX_W-1-CRD_W -: CRD_W];
    assign out_z     = out_vtx_reg[VX_W-1-2*CRD_W -: CRD_W];
    assign normal_x  = out_vtx_reg[VX_W-1-3*CRD_W -: CRD_W];
    assign normal_y  = out_vtx_reg[VX_W-1-4*CRD_W -: CRD_W];
    assign normal_z  = out_vtx_reg[VX_W-1-5*CRD_W -: CRD_W];
    assign out_u     = out_vtx_reg[UV_W-1 -: CRD_W];
    assign out_v     = out_vtx_reg[CRD_W-1:0];

    a_vcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VCNT_W'(VERTEX_DEPTH))
        else $error("vertex count beyond table depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken twice in a row");

    a_new_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_new && status != STAT_OK))
        else $error("appended vertex with error status");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH && hit) |-> (VCNT_W'(cmp_idx_reg) < vcount_reg))
        else $error("match on unwritten vertex entry");

endmodule
